// File: sv/rrhrv_pkg.sv
// shared constants, codes and state types for the rr interval hrv metrics block
// no dependencies; every other file imports this package

package rrhrv_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_MIN_MS      = 2'd1,
    CFG_MAX_MS      = 2'd2
  } cfg_idx_e;

  // field widths
  localparam int RateW   = 10;
  localparam int MsW     = 12;
  localparam int PeakW   = 24;
  localparam int HrW     = 22;
  localparam int RootW   = 20;
  localparam int CountW  = 13;
  localparam int FracW   = 16;
  localparam int NumW    = 34;

  // register reset values
  localparam logic [RateW-1:0] RateRst  = 10'd100;
  localparam logic [MsW-1:0]   MinMsRst = 12'd300;
  localparam logic [MsW-1:0]   MaxMsRst = 12'd1500;

  localparam logic [RateW-1:0] MsPerSec = 10'd1000;
  // 60000 ms per minute times 256 for q8
  localparam logic [23:0]      HrNum    = 24'd15360000;

  localparam int MaxIntervalsDef = 4096;
  localparam int QueueDepth      = 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_ACC,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL_C2,
    B_MUL_T1,
    B_MUL_S2,
    B_DIV_SD,
    B_SQRT_SD,
    B_MUL_HR,
    B_DIV_HR,
    B_RM_START,
    B_DIV_RM,
    B_SQRT_RM,
    B_OUT
  } back_state_e;

endpackage

// File: sv/rrhrv_if.sv
// valid/ready channel interfaces for peak words in and metric words out
// depends on rrhrv_pkg

interface rrhrv_in_if;
  import rrhrv_pkg::*;
  logic             valid;
  logic             ready;
  logic [PeakW-1:0] peak_sample_index;
  logic             set_end;

  modport source (output valid, output peak_sample_index, output set_end, input ready);
  modport sink   (input valid, input peak_sample_index, input set_end, output ready);
endinterface

interface rrhrv_out_if;
  import rrhrv_pkg::*;
  logic              valid;
  logic              ready;
  logic [HrW-1:0]    heart_rate_q8;
  logic [RootW-1:0]  sdnn_q8;
  logic [RootW-1:0]  rmssd_q8;
  logic [CountW-1:0] interval_count;
  logic              metrics_valid;
  logic              rmssd_valid;
  logic              intervals_dropped;

  modport source (output valid, output heart_rate_q8, output sdnn_q8, output rmssd_q8,
                  output interval_count, output metrics_valid, output rmssd_valid,
                  output intervals_dropped, input ready);
  modport sink   (input valid, input heart_rate_q8, input sdnn_q8, input rmssd_q8,
                  input interval_count, input metrics_valid, input rmssd_valid,
                  input intervals_dropped, output ready);
endinterface

// File: sv/rrhrv_front.sv
// front end: takes peak words, converts intervals to ms with a serial divider,
// filters and accumulates them, pushes a set snapshot on set end; uses rrhrv_pkg

module rrhrv_front #(
  parameter int MaxIntervals = rrhrv_pkg::MaxIntervalsDef,
  parameter int SnapW = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rrhrv_pkg::RateW-1:0]    rate_i,
  input  logic [rrhrv_pkg::MsW-1:0]      min_ms_i,
  input  logic [rrhrv_pkg::MsW-1:0]      max_ms_i,
  rrhrv_in_if.sink                       in_if,
  output logic                           push_o,
  output logic [SnapW-1:0]               snap_o,
  input  logic                           full_i
);
  import rrhrv_pkg::*;

  localparam int CntW = $clog2(MaxIntervals + 1);
  localparam int SumW = MsW + CntW;
  localparam int SqW  = 2 * MsW + CntW;
  localparam int StepW = $clog2(NumW + 1);

  front_state_e st_q, st_d;
  logic [PeakW-1:0] prev_q, prev_d;
  logic             have_q, have_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SqW-1:0]   sq_q, sq_d;
  logic [SqW-1:0]   dsq_q, dsq_d;
  logic [MsW-1:0]   last_q, last_d;
  logic             ovf_q, ovf_d;
  logic             end_q, end_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [RateW-1:0] rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;

  logic             accept;
  logic [PeakW-1:0] diff;
  logic [RateW:0]   trial;
  logic             ge;
  logic [MsW-1:0]   ms;
  logic             in_range;
  logic [MsW-1:0]   dabs;
  logic [2*MsW-1:0] ms_sq, d_sq;

  assign in_if.ready = (st_q == F_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign diff        = in_if.peak_sample_index - prev_q;

  // restoring divide step, one quotient bit a cycle
  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = trial >= {1'b0, rate_i};

  assign ms       = num_q[MsW-1:0];
  assign in_range = (num_q[NumW-1:MsW] == '0) && (ms >= min_ms_i) && (ms <= max_ms_i);
  assign dabs     = (ms >= last_q) ? (ms - last_q) : (last_q - ms);
  assign ms_sq    = (2*MsW)'(ms) * (2*MsW)'(ms);
  assign d_sq     = (2*MsW)'(dabs) * (2*MsW)'(dabs);

  assign snap_o = {ovf_q, dsq_q, sq_q, sum_q, cnt_q};

  always_comb begin
    st_d   = st_q;
    prev_d = prev_q;
    have_d = have_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    sq_d   = sq_q;
    dsq_d  = dsq_q;
    last_d = last_q;
    ovf_d  = ovf_q;
    end_d  = end_q;
    num_d  = num_q;
    rem_d  = rem_q;
    step_d = step_q;
    push_o = 1'b0;
    case (st_q)
      F_IDLE: begin
        if (accept) begin
          prev_d = in_if.peak_sample_index;
          have_d = 1'b1;
          end_d  = in_if.set_end;
          num_d  = NumW'(diff) * NumW'(MsPerSec);
          rem_d  = '0;
          step_d = StepW'(NumW);
          if (have_q && (in_if.peak_sample_index >= prev_q) && (rate_i != '0)) begin
            st_d = F_DIV;
          end else if (in_if.set_end) begin
            st_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        rem_d  = ge ? RateW'(trial - {1'b0, rate_i}) : trial[RateW-1:0];
        num_d  = {num_q[NumW-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          st_d = F_ACC;
        end
      end
      F_ACC: begin
        if (in_range) begin
          if (cnt_q >= CntW'(MaxIntervals)) begin
            ovf_d = 1'b1;
          end else begin
            if (cnt_q != '0) begin
              dsq_d = dsq_q + SqW'(d_sq);
            end
            cnt_d  = cnt_q + 1'b1;
            sum_d  = sum_q + SumW'(ms);
            sq_d   = sq_q + SqW'(ms_sq);
            last_d = ms;
          end
        end
        st_d = end_q ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          prev_d = '0;
          have_d = 1'b0;
          cnt_d  = '0;
          sum_d  = '0;
          sq_d   = '0;
          dsq_d  = '0;
          last_d = '0;
          ovf_d  = 1'b0;
          st_d   = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      prev_q <= '0;
      have_q <= 1'b0;
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      dsq_q  <= '0;
      last_q <= '0;
      ovf_q  <= 1'b0;
      end_q  <= 1'b0;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      prev_q <= prev_d;
      have_q <= have_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      sq_q   <= sq_d;
      dsq_q  <= dsq_d;
      last_q <= last_d;
      ovf_q  <= ovf_d;
      end_q  <= end_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

endmodule

// File: sv/rrhrv_fifo.sv
// small queue of set snapshots between front and back
// uses rrhrv_pkg for the default depth

module rrhrv_fifo #(
  parameter int Width = 1,
  parameter int Depth = rrhrv_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  import rrhrv_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

// File: sv/rrhrv_back.sv
// back end: computes heart rate, sdnn and rmssd from a set snapshot with
// shared serial multiply, divide and square-root steps; uses rrhrv_pkg

module rrhrv_back #(
  parameter int MaxIntervals = rrhrv_pkg::MaxIntervalsDef,
  parameter int SnapW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SnapW-1:0] snap_i,
  input  logic             empty_i,
  output logic             pop_o,
  rrhrv_out_if.source      out_if
);
  import rrhrv_pkg::*;

  localparam int CntW  = $clog2(MaxIntervals + 1);
  localparam int SumW  = MsW + CntW;
  localparam int SqW   = 2 * MsW + CntW;
  localparam int RawW  = SqW + CntW + FracW;
  localparam int DW    = ((RawW + 1) / 2) * 2;
  localparam int StepW = $clog2(DW + 1);
  localparam logic [DW-1:0] SqrtTop = DW'(1) << (DW - 2);

  back_state_e st_q, st_d;
  logic [SnapW-1:0] snap_q, snap_d;
  logic [DW-1:0]    a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DW-1:0]    c2_q, c2_d, t1_q, t1_d;
  logic [HrW-1:0]   hr_q, hr_d;
  logic [RootW-1:0] sd_q, sd_d, rm_q, rm_d;

  logic [CntW-1:0] n_in, n;
  logic [SumW-1:0] sum;
  logic [SqW-1:0]  sq, dsq;
  logic            ovf;
  logic            done;

  logic [DW-1:0] m_acc;
  logic [DW:0]   trial;
  logic          d_ge;
  logic [DW-1:0] d_rem, d_a;
  logic [DW-1:0] s_sum, s_a, s_acc;
  logic          s_ge;
  logic [DW-1:0] n_ext;

  assign n_in = snap_i[CntW-1:0];
  assign n    = snap_q[CntW-1:0];
  assign sum  = snap_q[CntW +: SumW];
  assign sq   = snap_q[CntW+SumW +: SqW];
  assign dsq  = snap_q[CntW+SumW+SqW +: SqW];
  assign ovf  = snap_q[SnapW-1];
  assign n_ext = DW'(n);
  assign done = (step_q == StepW'(1));

  // shift-add multiply step
  assign m_acc = b_q[0] ? acc_q + a_q : acc_q;
  // restoring divide step, quotient shifts into a
  assign trial = {acc_q, a_q[DW-1]};
  assign d_ge  = trial >= {1'b0, b_q};
  assign d_rem = d_ge ? DW'(trial - {1'b0, b_q}) : trial[DW-1:0];
  assign d_a   = {a_q[DW-2:0], d_ge};
  // square-root step: a holds remainder, acc the root, b the bit
  assign s_sum = acc_q + b_q;
  assign s_ge  = a_q >= s_sum;
  assign s_a   = s_ge ? a_q - s_sum : a_q;
  assign s_acc = s_ge ? (acc_q >> 1) + b_q : acc_q >> 1;

  always_comb begin
    st_d   = st_q;
    snap_d = snap_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    step_d = step_q;
    c2_d   = c2_q;
    t1_d   = t1_q;
    hr_d   = hr_q;
    sd_d   = sd_q;
    rm_d   = rm_q;
    pop_o  = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          snap_d = snap_i;
          hr_d   = '0;
          sd_d   = '0;
          rm_d   = '0;
          a_d    = DW'(n_in);
          b_d    = DW'(n_in);
          acc_d  = '0;
          step_d = StepW'(SumW);
          st_d   = (n_in == '0) ? B_OUT : B_MUL_C2;
        end
      end
      B_MUL_C2, B_MUL_T1, B_MUL_S2, B_MUL_HR: begin
        acc_d  = m_acc;
        a_d    = a_q << 1;
        b_d    = b_q >> 1;
        step_d = step_q - 1'b1;
        if (done) begin
          acc_d = '0;
          case (st_q)
            B_MUL_C2: begin
              c2_d   = m_acc;
              a_d    = DW'(sq);
              b_d    = n_ext;
              step_d = StepW'(SumW);
              st_d   = B_MUL_T1;
            end
            B_MUL_T1: begin
              t1_d   = m_acc;
              a_d    = DW'(sum);
              b_d    = DW'(sum);
              step_d = StepW'(SumW);
              st_d   = B_MUL_S2;
            end
            B_MUL_S2: begin
              a_d    = (t1_q - m_acc) << FracW;
              b_d    = c2_q;
              step_d = StepW'(DW);
              st_d   = B_DIV_SD;
            end
            default: begin
              a_d    = m_acc;
              b_d    = DW'(sum);
              step_d = StepW'(DW);
              st_d   = B_DIV_HR;
            end
          endcase
        end
      end
      B_DIV_SD, B_DIV_HR, B_DIV_RM: begin
        acc_d  = d_rem;
        a_d    = d_a;
        step_d = step_q - 1'b1;
        if (done) begin
          acc_d  = '0;
          b_d    = SqrtTop;
          step_d = StepW'(DW / 2);
          case (st_q)
            B_DIV_SD: st_d = B_SQRT_SD;
            B_DIV_RM: st_d = B_SQRT_RM;
            default: begin
              hr_d = (d_a[DW-1:HrW] != '0) ? '1 : d_a[HrW-1:0];
              st_d = B_RM_START;
            end
          endcase
        end
      end
      B_SQRT_SD, B_SQRT_RM: begin
        a_d    = s_a;
        acc_d  = s_acc;
        b_d    = b_q >> 2;
        step_d = step_q - 1'b1;
        if (done) begin
          if (st_q == B_SQRT_RM) begin
            rm_d = (s_acc[DW-1:RootW] != '0) ? '1 : s_acc[RootW-1:0];
            st_d = B_OUT;
          end else begin
            sd_d = (s_acc[DW-1:RootW] != '0) ? '1 : s_acc[RootW-1:0];
            acc_d = '0;
            if (sum == '0) begin
              // no beat length to divide by: saturate
              hr_d = '1;
              st_d = B_RM_START;
            end else begin
              a_d    = DW'(HrNum);
              b_d    = n_ext;
              step_d = StepW'(SumW);
              st_d   = B_MUL_HR;
            end
          end
        end
      end
      B_RM_START: begin
        acc_d  = '0;
        a_d    = DW'(dsq) << FracW;
        b_d    = n_ext - 1'b1;
        step_d = StepW'(DW);
        st_d   = (n > CntW'(1)) ? B_DIV_RM : B_OUT;
      end
      B_OUT: begin
        if (out_if.ready) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  assign out_if.valid             = (st_q == B_OUT);
  assign out_if.heart_rate_q8     = hr_q;
  assign out_if.sdnn_q8           = sd_q;
  assign out_if.rmssd_q8          = rm_q;
  assign out_if.interval_count    = n_ext[CountW-1:0];
  assign out_if.metrics_valid     = (n != '0);
  assign out_if.rmssd_valid       = (n > CntW'(1));
  assign out_if.intervals_dropped = ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    c2_q   <= c2_d;
    t1_q   <= t1_d;
    hr_q   <= hr_d;
    sd_q   <= sd_d;
    rm_q   <= rm_d;
  end

endmodule

// File: sv/rr_interval_hrv_metrics.sv
// top level of the rr interval hrv metrics block: config registers, front, queue, back
// depends on rrhrv_pkg, rrhrv_if, rrhrv_front, rrhrv_fifo, rrhrv_back

// Peak sample indices enter one word at a time on in_if; a set_end word closes
// the set and yields one metrics word on out_if (heart rate, sdnn and rmssd in
// q8). A peak that opens a new interval holds the input in the front end while
// its one-bit-a-cycle divider divides the 34-bit product of sample span and 1000
// by the sample rate and the accumulate state adds the result; a set_end word
// also passes through a push state that waits while the queue is full. A
// closed set is queued (two deep) and the back end works on it alone: four
// serial multiplies of (width of the interval sum, 25 at the default capacity)
// steps, up to three serial divides of DW steps and two square roots of DW/2
// steps, DW being the width of the 65536-scaled variance numerator (66 bits at
// the default capacity), and then waits for the output handshake. Peaks keep
// flowing in while the back end works. Config is written with cfg_we_i, cfg_idx_i
// and cfg_data_i while the block is idle; unknown indexes are ignored.

module rr_interval_hrv_metrics #(
  parameter int MaxIntervals = rrhrv_pkg::MaxIntervalsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rrhrv_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rrhrv_pkg::CfgDataW-1:0]   cfg_data_i,
  rrhrv_in_if.sink                         in_if,
  rrhrv_out_if.source                      out_if
);
  import rrhrv_pkg::*;

  localparam int CntW  = $clog2(MaxIntervals + 1);
  localparam int SnapW = 1 + 2 * (2 * MsW + CntW) + (MsW + CntW) + CntW;

  // config registers
  logic [RateW-1:0] rate_q;
  logic [MsW-1:0]   min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateRst;
      min_q  <= MinMsRst;
      max_q  <= MaxMsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_RATE: rate_q <= cfg_data_i[RateW-1:0];
        CFG_MIN_MS:      min_q  <= cfg_data_i[MsW-1:0];
        CFG_MAX_MS:      max_q  <= cfg_data_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  // snapshot queue between front and back
  logic             push, pop, full, empty;
  logic [SnapW-1:0] snap_in, snap_out;

  rrhrv_front #(
    .MaxIntervals(MaxIntervals),
    .SnapW(SnapW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rate_i  (rate_q),
    .min_ms_i(min_q),
    .max_ms_i(max_q),
    .in_if   (in_if),
    .push_o  (push),
    .snap_o  (snap_in),
    .full_i  (full)
  );

  rrhrv_fifo #(
    .Width(SnapW),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (snap_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (snap_out),
    .empty_o(empty)
  );

  rrhrv_back #(
    .MaxIntervals(MaxIntervals),
    .SnapW(SnapW)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .snap_i (snap_out),
    .empty_i(empty),
    .pop_o  (pop),
    .out_if (out_if)
  );

  // an empty set reports zero metrics
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.metrics_valid |->
      out_if.heart_rate_q8 == '0 && out_if.sdnn_q8 == '0 && out_if.rmssd_q8 == '0)
    else $error("metrics nonzero without kept intervals");

  // rmssd needs two intervals, which implies metrics are valid
  a_rmssd_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.rmssd_valid |-> out_if.metrics_valid)
    else $error("rmssd valid without metrics valid");

  a_rmssd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.rmssd_valid |-> out_if.rmssd_q8 == '0)
    else $error("rmssd nonzero with flag clear");

  // queue never pushed while full
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("snapshot pushed into full queue");

endmodule
